>>> rtl/vcsp_pkg.sv
package vcsp_pkg;

   // Stream opcodes
   localparam logic [7:0] OP_STEREO    = 8'h31;
   localparam logic [7:0] OP_PSG_WRITE = 8'h50;
   localparam logic [7:0] OP_AY_WRITE  = 8'hA0;
   localparam logic [7:0] OP_NES_WRITE = 8'hB4;
   localparam logic [7:0] OP_DATA_BLK  = 8'h67;
   localparam logic [7:0] OP_WAIT_N    = 8'h61;
   localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
   localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
   localparam logic [7:0] OP_END       = 8'h66;
   localparam logic [7:0] OP_SHORT_LO  = 8'h70;
   localparam logic [7:0] OP_SHORT_HI  = 8'h7F;

   localparam logic [15:0] WAIT_NTSC = 16'd735;
   localparam logic [15:0] WAIT_PAL  = 16'd882;

   localparam logic [7:0] AY_ADDR_MASK = 8'h7F;

   // Result kinds
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_WAIT    = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // chip_type codes
   localparam logic [1:0] CHIP_PSG = 2'd0;
   localparam logic [1:0] CHIP_AY  = 2'd1;
   localparam logic [1:0] CHIP_NES = 2'd2;
   localparam logic [1:0] CHIP_TYPE_RESET = CHIP_AY;

   // CSR register index
   localparam logic REG_CHIP_TYPE = 1'b0;

   // Decoded command passed from the parser to the result stage
   typedef enum logic [2:0] {
      CMD_PSG     = 3'd0,
      CMD_AY      = 3'd1,
      CMD_NES     = 3'd2,
      CMD_WAIT    = 3'd3,
      CMD_END     = 3'd4,
      CMD_UNKNOWN = 3'd5
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] arg_a;   // register byte, or wait low byte
      logic [7:0] arg_b;   // value byte, or wait high byte
   } cmd_rec_type;

   typedef struct packed {
      logic        push;
      cmd_rec_type rec;
   } cmd_push_type;

endpackage

>>> rtl/vcsp_front.sv
module vcsp_front
   import vcsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_accept,
   input  logic [7:0]   in_byte,
   output cmd_push_type cmd_out
);

   typedef enum logic [15:0] {
      PH_OPCODE   = 16'h0001,
      PH_STEREO   = 16'h0002,
      PH_PSG_VAL  = 16'h0004,
      PH_AY_ADDR  = 16'h0008,
      PH_AY_VAL   = 16'h0010,
      PH_NES_ADDR = 16'h0020,
      PH_NES_VAL  = 16'h0040,
      PH_WAIT_LO  = 16'h0080,
      PH_WAIT_HI  = 16'h0100,
      PH_DB_MARK  = 16'h0200,
      PH_DB_TYPE  = 16'h0400,
      PH_DB_LEN0  = 16'h0800,
      PH_DB_LEN1  = 16'h1000,
      PH_DB_LEN2  = 16'h2000,
      PH_DB_LEN3  = 16'h4000,
      PH_DB_DATA  = 16'h8000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic [31:0] skip_ff, skip_in;
   logic        halted_ff, halted_in;

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      skip_in   = skip_ff;
      halted_in = halted_ff;
      cmd_out.push      = 1'b0;
      cmd_out.rec.cmd   = CMD_WAIT;
      cmd_out.rec.arg_a = 8'h00;
      cmd_out.rec.arg_b = 8'h00;
      if (in_accept && !halted_ff) begin
         case (phase_ff)
            PH_OPCODE: begin
               case (in_byte) inside
                  OP_STEREO:    phase_in = PH_STEREO;
                  OP_PSG_WRITE: phase_in = PH_PSG_VAL;
                  OP_AY_WRITE:  phase_in = PH_AY_ADDR;
                  OP_NES_WRITE: phase_in = PH_NES_ADDR;
                  OP_DATA_BLK:  phase_in = PH_DB_MARK;
                  OP_WAIT_N:    phase_in = PH_WAIT_LO;
                  OP_WAIT_NTSC: begin
                     cmd_out.push      = 1'b1;
                     cmd_out.rec.arg_a = WAIT_NTSC[7:0];
                     cmd_out.rec.arg_b = WAIT_NTSC[15:8];
                  end
                  OP_WAIT_PAL: begin
                     cmd_out.push      = 1'b1;
                     cmd_out.rec.arg_a = WAIT_PAL[7:0];
                     cmd_out.rec.arg_b = WAIT_PAL[15:8];
                  end
                  OP_END: begin
                     cmd_out.push    = 1'b1;
                     cmd_out.rec.cmd = CMD_END;
                     halted_in       = 1'b1;
                  end
                  [OP_SHORT_LO:OP_SHORT_HI]: begin
                     // short wait: low nibble + 1
                     cmd_out.push      = 1'b1;
                     cmd_out.rec.arg_a = {4'h0, in_byte[3:0]} + 8'd1;
                  end
                  default: begin
                     cmd_out.push    = 1'b1;
                     cmd_out.rec.cmd = CMD_UNKNOWN;
                     halted_in       = 1'b1;
                  end
               endcase
            end
            PH_STEREO: phase_in = PH_OPCODE;
            PH_PSG_VAL: begin
               cmd_out.push      = 1'b1;
               cmd_out.rec.cmd   = CMD_PSG;
               cmd_out.rec.arg_b = in_byte;
               phase_in          = PH_OPCODE;
            end
            PH_AY_ADDR: begin
               held_in  = in_byte;
               phase_in = PH_AY_VAL;
            end
            PH_AY_VAL: begin
               cmd_out.push      = 1'b1;
               cmd_out.rec.cmd   = CMD_AY;
               cmd_out.rec.arg_a = held_ff;
               cmd_out.rec.arg_b = in_byte;
               phase_in          = PH_OPCODE;
            end
            PH_NES_ADDR: begin
               held_in  = in_byte;
               phase_in = PH_NES_VAL;
            end
            PH_NES_VAL: begin
               cmd_out.push      = 1'b1;
               cmd_out.rec.cmd   = CMD_NES;
               cmd_out.rec.arg_a = held_ff;
               cmd_out.rec.arg_b = in_byte;
               phase_in          = PH_OPCODE;
            end
            PH_WAIT_LO: begin
               held_in  = in_byte;
               phase_in = PH_WAIT_HI;
            end
            PH_WAIT_HI: begin
               // zero length is dropped in the result stage
               cmd_out.push      = 1'b1;
               cmd_out.rec.arg_a = held_ff;
               cmd_out.rec.arg_b = in_byte;
               phase_in          = PH_OPCODE;
            end
            PH_DB_MARK: phase_in = PH_DB_TYPE;
            PH_DB_TYPE: begin
               skip_in  = 32'h0;
               phase_in = PH_DB_LEN0;
            end
            PH_DB_LEN0: begin
               skip_in  = {24'h0, in_byte};
               phase_in = PH_DB_LEN1;
            end
            PH_DB_LEN1: begin
               skip_in[15:8] = in_byte;
               phase_in      = PH_DB_LEN2;
            end
            PH_DB_LEN2: begin
               skip_in[23:16] = in_byte;
               phase_in       = PH_DB_LEN3;
            end
            PH_DB_LEN3: begin
               skip_in[31:24] = in_byte;
               if ({in_byte, skip_ff[23:0]} == 32'h0) begin
                  phase_in = PH_OPCODE;
               end else begin
                  phase_in = PH_DB_DATA;
               end
            end
            PH_DB_DATA: begin
               if (skip_ff != 32'h0) begin
                  skip_in = skip_ff - 32'd1;
               end
               if (skip_ff <= 32'd1) begin
                  phase_in = PH_OPCODE;
               end
            end
            default: phase_in = PH_OPCODE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         held_ff   <= 8'h00;
         skip_ff   <= 32'h0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         skip_ff   <= skip_in;
         halted_ff <= halted_in;
      end
   end

   // once halted, stays halted and emits nothing
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("parser left halt without reset");

   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !cmd_out.push)
      else $error("parser emitted a command while halted");

endmodule

>>> rtl/vcsp_queue.sv
module vcsp_queue
   import vcsp_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_push_type wr,
   input  logic         pop,
   output cmd_rec_type  head,
   output logic         full,
   output logic         empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CFULL = CW'(DEPTH);

   cmd_rec_type   slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CFULL);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr.push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !wr.push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         slot_ff[wr_ptr_ff] <= wr.rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr.push |-> !full)
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue underflow");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (wr.push && !pop) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("command queue count did not advance on push");

endmodule

>>> rtl/vcsp_back.sv
module vcsp_back
   import vcsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  chip_type,
   input  logic        q_empty,
   input  cmd_rec_type q_head,
   output logic        q_pop,
   output logic        out_valid,
   input  logic        out_stall,
   output logic [1:0]  out_kind,
   output logic        out_chip_index,
   output logic [7:0]  out_reg_addr,
   output logic [7:0]  out_reg_value,
   output logic [15:0] out_wait_samples
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic        chip_ff, chip_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  value_ff, value_in;
   logic [15:0] wait_ff, wait_in;
   logic        keep;
   logic        load;

   assign load  = !valid_ff || !out_stall;
   assign q_pop = load && !q_empty;

   // format the head command; mismatched writes and zero waits are dropped
   always_comb begin
      keep    = 1'b1;
      kind_in = KIND_WRITE;
      chip_in = 1'b0;
      addr_in = 8'h00;
      value_in = 8'h00;
      wait_in = 16'h0;
      case (q_head.cmd)
         CMD_PSG: begin
            keep     = (chip_type == CHIP_PSG);
            value_in = q_head.arg_b;
         end
         CMD_AY: begin
            keep     = (chip_type == CHIP_AY);
            chip_in  = q_head.arg_a[7];
            addr_in  = q_head.arg_a & AY_ADDR_MASK;
            value_in = q_head.arg_b;
         end
         CMD_NES: begin
            keep     = (chip_type == CHIP_NES);
            addr_in  = q_head.arg_a;
            value_in = q_head.arg_b;
         end
         CMD_WAIT: begin
            kind_in = KIND_WAIT;
            wait_in = {q_head.arg_b, q_head.arg_a};
            keep    = (wait_in != 16'h0);
         end
         CMD_END:     kind_in = KIND_END;
         CMD_UNKNOWN: kind_in = KIND_UNKNOWN;
         default:     keep = 1'b0;
      endcase
      valid_in = valid_ff;
      if (load) begin
         valid_in = !q_empty && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         chip_ff  <= chip_in;
         addr_ff  <= addr_in;
         value_ff <= value_in;
         wait_ff  <= wait_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_kind         = kind_ff;
   assign out_chip_index   = chip_ff;
   assign out_reg_addr     = addr_ff;
   assign out_reg_value    = value_ff;
   assign out_wait_samples = wait_ff;

endmodule

>>> rtl/vgm_command_stream_parser_top.sv
// A completed command is registered in the command queue, then in the output register.
// Throughput: one stream byte per cycle sustained; the parser does constant work per byte.
// Bytes are stalled only when the command queue between parser and result stage is full.
// Reset (synchronous, active high): parser back to opcode, halt cleared, queue and
// output register emptied, chip_type set to the AY family.
module vgm_command_stream_parser_top
   import vcsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   // stream byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic        rsp_chip_index,
   output logic [7:0]  rsp_reg_addr,
   output logic [7:0]  rsp_reg_value,
   output logic [15:0] rsp_wait_samples,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------
   // Register file: a single register, chip_type, at byte address 0.
   // paddr[2] selects past the register list; such writes are dropped.
   // ---------------------------------------------------------------
   logic [1:0] chip_type_ff, chip_type_in;
   logic       csr_write;
   logic       csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_CHIP_TYPE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_hit;

   always_comb begin
      chip_type_in = chip_type_ff;
      if (csr_write) begin
         chip_type_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_type_ff <= CHIP_TYPE_RESET;
      end else begin
         chip_type_ff <= chip_type_in;
      end
   end

   assign csr_prdata = csr_hit ? {30'h0, chip_type_ff} : 32'h0;

   // ---------------------------------------------------------------
   // Front end: byte-level parser. It decodes opcodes and arguments and
   // pushes one decoded command per completed write, wait, end or unknown opcode.
   // It accepts a byte every cycle unless the queue is full.
   // ---------------------------------------------------------------
   cmd_push_type cmd_wr;
   cmd_rec_type  q_head;
   logic         q_full;
   logic         q_empty;
   logic         q_pop;
   logic         req_accept;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   vcsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_stream_byte),
      .cmd_out   (cmd_wr)
   );

   // Short command queue decouples parsing from result delivery.
   vcsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (cmd_wr),
      .pop   (q_pop),
      .head  (q_head),
      .full  (q_full),
      .empty (q_empty)
   );

   // ---------------------------------------------------------------
   // Back end: filters writes by chip_type, drops zero waits, and holds
   // each result in an output register until the transaction completes.
   // Pops one command per cycle while the output register is empty or not stalled.
   // ---------------------------------------------------------------
   vcsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .chip_type        (chip_type_ff),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .out_valid        (rsp_valid),
      .out_stall        (rsp_stall),
      .out_kind         (rsp_kind),
      .out_chip_index   (rsp_chip_index),
      .out_reg_addr     (rsp_reg_addr),
      .out_reg_value    (rsp_reg_value),
      .out_wait_samples (rsp_wait_samples)
   );

endmodule
